// ===== rtl/stog_pkg.sv =====
`timescale 1ns / 1ps

package stog_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE_LOG2 = 2'd2;

    localparam int SIDE_CFG_W  = 9;
    localparam int SHIFT_CFG_W = 4;

    localparam logic [SIDE_CFG_W-1:0]  GRID_COLUMNS_RST   = 9'd80;
    localparam logic [SIDE_CFG_W-1:0]  GRID_ROWS_RST      = 9'd45;
    localparam logic [SHIFT_CFG_W-1:0] TILE_SIZE_LOG2_RST = 4'd4;
    localparam logic [SHIFT_CFG_W-1:0] MAX_TILE_SHIFT     = 4'd8;

    // Result field widths.
    localparam int TILE_W  = 8;
    localparam int PIXEL_W = 16;
    localparam int ORDER_W = 16;

    // Walk headings.
    localparam logic [1:0] HEAD_RIGHT = 2'd0;
    localparam logic [1:0] HEAD_DOWN  = 2'd1;
    localparam logic [1:0] HEAD_LEFT  = 2'd2;
    localparam logic [1:0] HEAD_UP    = 2'd3;

    typedef struct packed {
        logic capture;
        logic calc_total;
        logic center;
        logic start_walk;
        logic advance;
        logic load_out;
        logic found;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_below_total;
        logic hit;
        logic spiral_done;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/stog_ctrl.sv =====
`timescale 1ns / 1ps

module stog_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stog_pkg::t_dp_status i_status,
    output stog_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_STEP   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_found;
    logic       n_found;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_found = r_found;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.calc_total = 1'b1;
                n_state          = S_DECIDE;
            end
            S_DECIDE: begin
                if (!i_status.count_below_total) begin
                    n_found = 1'b0;
                    n_state = S_EMIT;
                end else if (i_status.count_zero) begin
                    o_cmd.center = 1'b1;
                    n_found      = 1'b1;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.start_walk = 1'b1;
                    n_state          = S_STEP;
                end
            end
            S_STEP: begin
                if (i_status.hit) begin
                    n_found = 1'b1;
                    n_state = S_EMIT;
                end else if (i_status.spiral_done) begin
                    n_found = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.found    = r_found;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

    // A position inside the grid always ends the walk with a tile.
    a_hit_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) && i_status.hit |=> (r_state == S_EMIT) && r_found)
        else $error("walk hit did not lead to a tile result");

    // The spiral never advances once it already covers every grid.
    a_no_runaway: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.advance |-> !i_status.spiral_done)
        else $error("walk advanced past the spiral limit");

    // A result is only loaded while the output register can take it.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free && (r_state == S_EMIT))
        else $error("result loaded over a waiting result");

    // A new item always starts with the total computed from the latched sizes.
    a_prep_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_PREP) ##1 (r_state == S_DECIDE))
        else $error("item skipped the preparation steps");

endmodule

// ===== rtl/stog_dp.sv =====
`timescale 1ns / 1ps

module stog_dp #(
    parameter int MAX_GRID_SIDE = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  stog_pkg::t_dp_cmd                    i_cmd,
    output stog_pkg::t_dp_status                 o_status,
    input  logic                                 i_restart,
    input  logic [stog_pkg::SIDE_CFG_W-1:0]      i_grid_columns,
    input  logic [stog_pkg::SIDE_CFG_W-1:0]      i_grid_rows,
    input  logic [stog_pkg::SHIFT_CFG_W-1:0]     i_tile_size_log2,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [stog_pkg::TILE_W-1:0]          o_tile_column,
    output logic [stog_pkg::TILE_W-1:0]          o_tile_row,
    output logic [stog_pkg::PIXEL_W-1:0]         o_pixel_x,
    output logic [stog_pkg::PIXEL_W-1:0]         o_pixel_y,
    output logic [stog_pkg::ORDER_W-1:0]         o_order_number,
    output logic                                 o_is_last,
    output logic                                 o_exhausted
);

    localparam int SW           = $clog2(MAX_GRID_SIDE + 1);
    localparam int TW           = 2 * SW;
    localparam int CW           = $clog2(MAX_GRID_SIDE * MAX_GRID_SIDE + 1);
    localparam int SPIRAL_LIMIT = 2 * MAX_GRID_SIDE + 2;
    localparam int RW           = $clog2(SPIRAL_LIMIT + 2);
    localparam int WW           = RW + 1;

    // Sizes latched when an item is taken, and the tile total computed from them.
    logic [SW-1:0]                       r_cols;
    logic [SW-1:0]                       r_rows;
    logic [stog_pkg::SHIFT_CFG_W-1:0]    r_shift;
    logic [TW-1:0]                       r_total;

    // Walk state.
    logic [CW-1:0]        r_count;
    logic signed [WW-1:0] r_wcol;
    logic signed [WW-1:0] r_wrow;
    logic [1:0]           r_heading;
    logic [RW-1:0]        r_run;
    logic [RW-1:0]        r_step;
    logic                 r_pair;
    logic                 r_moved;

    logic r_out_valid;

    logic [RW-1:0]                n_step_inc;
    logic                         in_grid;
    logic [stog_pkg::PIXEL_W-1:0] col_wide;
    logic [stog_pkg::PIXEL_W-1:0] row_wide;
    logic [TW-1:0]                count_ext;

    assign n_step_inc = r_step + RW'(1);
    assign count_ext  = TW'(r_count);

    assign in_grid = !r_wcol[WW-1] && !r_wrow[WW-1]
                  && (r_wcol < $signed({1'b0, r_cols}))
                  && (r_wrow < $signed({1'b0, r_rows}));

    assign col_wide = stog_pkg::PIXEL_W'(unsigned'(r_wcol));
    assign row_wide = stog_pkg::PIXEL_W'(unsigned'(r_wrow));

    assign o_status.count_zero        = (r_count == '0);
    assign o_status.count_below_total = (count_ext < r_total);
    assign o_status.hit               = r_moved && in_grid;
    assign o_status.spiral_done       = (r_run > RW'(SPIRAL_LIMIT));
    assign o_status.out_free          = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_wcol    <= '0;
            r_wrow    <= '0;
            r_heading <= stog_pkg::HEAD_RIGHT;
            r_run     <= RW'(1);
            r_step    <= '0;
            r_pair    <= 1'b0;
            r_moved   <= 1'b0;
        end else begin
            if (i_cmd.capture && i_restart) begin
                r_count <= '0;
            end
            if (i_cmd.center) begin
                r_wcol    <= WW'({1'b0, (r_cols >> 1)});
                r_wrow    <= WW'({1'b0, (r_rows >> 1)});
                r_heading <= stog_pkg::HEAD_RIGHT;
                r_run     <= RW'(1);
                r_step    <= '0;
                r_pair    <= 1'b0;
            end
            if (i_cmd.start_walk) begin
                r_moved <= 1'b0;
            end
            if (i_cmd.advance) begin
                r_moved <= 1'b1;
                unique case (r_heading)
                    stog_pkg::HEAD_RIGHT: r_wcol <= r_wcol + WW'(1);
                    stog_pkg::HEAD_DOWN:  r_wrow <= r_wrow + WW'(1);
                    stog_pkg::HEAD_LEFT:  r_wcol <= r_wcol - WW'(1);
                    default:              r_wrow <= r_wrow - WW'(1);
                endcase
                if (n_step_inc >= r_run) begin
                    r_step    <= '0;
                    r_heading <= r_heading + 2'd1;
                    r_pair    <= !r_pair;
                    if (r_pair) begin
                        r_run <= r_run + RW'(1);
                    end
                end else begin
                    r_step <= n_step_inc;
                end
            end
            if (i_cmd.load_out && i_cmd.found) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // Effective sizes: clamp to the grid limit and to the largest tile shift, then form the tile total.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cols  <= (i_grid_columns > MAX_GRID_SIDE) ? SW'(MAX_GRID_SIDE)
                                                        : SW'(i_grid_columns);
            r_rows  <= (i_grid_rows > MAX_GRID_SIDE) ? SW'(MAX_GRID_SIDE)
                                                     : SW'(i_grid_rows);
            r_shift <= (i_tile_size_log2 > stog_pkg::MAX_TILE_SHIFT)
                       ? stog_pkg::MAX_TILE_SHIFT : i_tile_size_log2;
        end
        if (i_cmd.calc_total) begin
            r_total <= TW'(r_cols) * TW'(r_rows);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.found) begin
                o_tile_column  <= stog_pkg::TILE_W'(col_wide);
                o_tile_row     <= stog_pkg::TILE_W'(row_wide);
                o_pixel_x      <= col_wide << r_shift;
                o_pixel_y      <= row_wide << r_shift;
                o_order_number <= stog_pkg::ORDER_W'(r_count);
                o_is_last      <= ((count_ext + TW'(1)) == r_total);
                o_exhausted    <= 1'b0;
            end else begin
                o_tile_column  <= '0;
                o_tile_row     <= '0;
                o_pixel_x      <= '0;
                o_pixel_y      <= '0;
                o_order_number <= '0;
                o_is_last      <= 1'b0;
                o_exhausted    <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/spiral_tile_order_generator_unit.sv =====
`timescale 1ns / 1ps

// Spiral tile order generator. Each request item returns one result item: the
// next tile of an outward square spiral that starts at the center tile of the
// grid, or an exhausted flag once every tile has been handed out or the walk
// passes the spiral limit; restart set begins the walk again. A request that
// returns the first tile of a walk, or that finds the tile count already
// reached, passes through the prepare, decide and emit states without walking.
// Any other request walks the spiral with its position held in column and row
// registers, stepped once a cycle and tested against the grid bounds on the next;
// it walks the next tile's position and every off-grid position skipped before
// it, or every position up to the spiral limit when no tile is found. Each
// request's result appears in the same cycle as the input frees.
// A finished result waits in the output register while the next request is
// taken; a request whose result is ready waits further, with the input held
// off, for as long as the previous result is stalled there.
// Grid sizes and tile shift are sampled when a request is taken.
module spiral_tile_order_generator_unit #(
    parameter int MAX_GRID_SIDE = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_restart,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [stog_pkg::TILE_W-1:0]       o_tile_column,
    output logic [stog_pkg::TILE_W-1:0]       o_tile_row,
    output logic [stog_pkg::PIXEL_W-1:0]      o_pixel_x,
    output logic [stog_pkg::PIXEL_W-1:0]      o_pixel_y,
    output logic [stog_pkg::ORDER_W-1:0]      o_order_number,
    output logic                              o_is_last,
    output logic                              o_exhausted,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [stog_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [stog_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [stog_pkg::SIDE_CFG_W-1:0]  r_grid_columns;
    logic [stog_pkg::SIDE_CFG_W-1:0]  r_grid_rows;
    logic [stog_pkg::SHIFT_CFG_W-1:0] r_tile_size_log2;

    stog_pkg::t_dp_cmd    cmd;
    stog_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns   <= stog_pkg::GRID_COLUMNS_RST;
            r_grid_rows      <= stog_pkg::GRID_ROWS_RST;
            r_tile_size_log2 <= stog_pkg::TILE_SIZE_LOG2_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                stog_pkg::CFG_GRID_COLUMNS: begin
                    r_grid_columns <= stog_pkg::SIDE_CFG_W'(i_cfg_data);
                end
                stog_pkg::CFG_GRID_ROWS: begin
                    r_grid_rows <= stog_pkg::SIDE_CFG_W'(i_cfg_data);
                end
                stog_pkg::CFG_TILE_SIZE_LOG2: begin
                    r_tile_size_log2 <= stog_pkg::SHIFT_CFG_W'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    stog_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    stog_dp #(
        .MAX_GRID_SIDE (MAX_GRID_SIDE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_restart        (i_restart),
        .i_grid_columns   (r_grid_columns),
        .i_grid_rows      (r_grid_rows),
        .i_tile_size_log2 (r_tile_size_log2),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_tile_column    (o_tile_column),
        .o_tile_row       (o_tile_row),
        .o_pixel_x        (o_pixel_x),
        .o_pixel_y        (o_pixel_y),
        .o_order_number   (o_order_number),
        .o_is_last        (o_is_last),
        .o_exhausted      (o_exhausted)
    );

endmodule

// ===== tb/sv/tb_spiral_tile_order_generator_unit.sv =====
`timescale 1ns / 1ps

module tb_spiral_tile_order_generator_unit;

    localparam int CLK_PERIOD  = 12;
    localparam int SIDE_MAX    = 256;
    localparam int RUN_LIMIT   = 2 * SIDE_MAX + 2;
    // A walk that runs out can step through about 265k spiral positions.
    localparam int CYCLE_LIMIT = 250_000_000;
    localparam int SETTLE      = 8;
    localparam int REPORT_MAX  = 10;

    // Index 3 names no register; writes to it must be ignored.
    localparam logic [stog_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [stog_pkg::TILE_W-1:0]  tile_column;
        logic [stog_pkg::TILE_W-1:0]  tile_row;
        logic [stog_pkg::PIXEL_W-1:0] pixel_x;
        logic [stog_pkg::PIXEL_W-1:0] pixel_y;
        logic [stog_pkg::ORDER_W-1:0] order_number;
        logic                         is_last;
        logic                         exhausted;
    } t_tile_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic                            i_restart = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [stog_pkg::TILE_W-1:0]     o_tile_column;
    logic [stog_pkg::TILE_W-1:0]     o_tile_row;
    logic [stog_pkg::PIXEL_W-1:0]    o_pixel_x;
    logic [stog_pkg::PIXEL_W-1:0]    o_pixel_y;
    logic [stog_pkg::ORDER_W-1:0]    o_order_number;
    logic                            o_is_last;
    logic                            o_exhausted;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [stog_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [stog_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    spiral_tile_order_generator_unit #(
        .MAX_GRID_SIDE(SIDE_MAX)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_restart(i_restart),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_tile_column(o_tile_column),
        .o_tile_row(o_tile_row),
        .o_pixel_x(o_pixel_x),
        .o_pixel_y(o_pixel_y),
        .o_order_number(o_order_number),
        .o_is_last(o_is_last),
        .o_exhausted(o_exhausted),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Mirror of the configuration registers and of the spiral walk.
    logic [stog_pkg::SIDE_CFG_W-1:0]  grid_cols_q = stog_pkg::GRID_COLUMNS_RST;
    logic [stog_pkg::SIDE_CFG_W-1:0]  grid_rows_q = stog_pkg::GRID_ROWS_RST;
    logic [stog_pkg::SHIFT_CFG_W-1:0] tile_shift_q = stog_pkg::TILE_SIZE_LOG2_RST;
    int                               walk_col = 0;
    int                               walk_row = 0;
    logic [1:0]                       walk_dir = stog_pkg::HEAD_RIGHT;
    int                               run_len = 1;
    int                               run_pos = 0;
    bit                               pair_second = 1'b0;
    logic [16:0]                      tiles_given = '0;

    t_tile_result pending_tiles[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int requests_sent = 0;
    int restarts_sent = 0;
    int tiles_checked = 0;
    int exhausted_seen = 0;

    function automatic int clamp_side(input logic [stog_pkg::SIDE_CFG_W-1:0] side);
        return (side > SIDE_MAX) ? SIDE_MAX : int'(side);
    endfunction

    function automatic t_tile_result next_spiral_tile(input logic restart);
        t_tile_result res;
        int cols;
        int rows;
        int total;
        int shift;
        bit hit;
        cols  = clamp_side(grid_cols_q);
        rows  = clamp_side(grid_rows_q);
        total = cols * rows;
        shift = (tile_shift_q > stog_pkg::MAX_TILE_SHIFT)
              ? int'(stog_pkg::MAX_TILE_SHIFT) : int'(tile_shift_q);
        res   = '0;
        hit   = 1'b0;
        if (restart)
            tiles_given = '0;
        if (int'(tiles_given) < total) begin
            if (tiles_given == 0) begin
                walk_col    = cols / 2;
                walk_row    = rows / 2;
                walk_dir    = stog_pkg::HEAD_RIGHT;
                run_len     = 1;
                run_pos     = 0;
                pair_second = 1'b0;
                hit         = 1'b1;
            end else begin
                // Off-grid positions are stepped over; once the run length passes
                // the limit every possible grid has been covered.
                while (!hit && run_len <= RUN_LIMIT) begin
                    case (walk_dir)
                        stog_pkg::HEAD_RIGHT: walk_col += 1;
                        stog_pkg::HEAD_DOWN:  walk_row += 1;
                        stog_pkg::HEAD_LEFT:  walk_col -= 1;
                        default:              walk_row -= 1;
                    endcase
                    run_pos += 1;
                    if (run_pos >= run_len) begin
                        run_pos  = 0;
                        walk_dir = walk_dir + 2'd1;
                        if (pair_second)
                            run_len += 1;
                        pair_second = !pair_second;
                    end
                    hit = walk_col >= 0 && walk_col < cols && walk_row >= 0 && walk_row < rows;
                end
            end
        end
        if (!hit) begin
            res.exhausted = 1'b1;
        end else begin
            res.tile_column  = stog_pkg::TILE_W'(walk_col);
            res.tile_row     = stog_pkg::TILE_W'(walk_row);
            res.pixel_x      = stog_pkg::PIXEL_W'(walk_col << shift);
            res.pixel_y      = stog_pkg::PIXEL_W'(walk_row << shift);
            res.order_number = tiles_given[stog_pkg::ORDER_W-1:0];
            res.is_last      = (int'(tiles_given) + 1 == total);
            tiles_given      = tiles_given + 17'd1;
        end
        return res;
    endfunction

    function automatic logic [stog_pkg::SIDE_CFG_W-1:0] random_side();
        case ($urandom_range(9))
            0: begin
                if ($urandom_range(1) != 0)
                    return '0;
                return stog_pkg::SIDE_CFG_W'($urandom_range(511, 257));
            end
            1: return stog_pkg::SIDE_CFG_W'($urandom_range(256, 13));
            default: return stog_pkg::SIDE_CFG_W'($urandom_range(12, 1));
        endcase
    endfunction

    task automatic send_request(input logic restart);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (o_in_stall);
        pending_tiles.push_back(next_spiral_tile(restart));
        requests_sent++;
        if (restart)
            restarts_sent++;
    endtask

    task automatic write_reg(input logic [stog_pkg::CFG_IDX_W-1:0] idx,
                             input logic [stog_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            stog_pkg::CFG_GRID_COLUMNS:   grid_cols_q = data[stog_pkg::SIDE_CFG_W-1:0];
            stog_pkg::CFG_GRID_ROWS:      grid_rows_q = data[stog_pkg::SIDE_CFG_W-1:0];
            stog_pkg::CFG_TILE_SIZE_LOG2: tile_shift_q = data[stog_pkg::SHIFT_CFG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Lets every outstanding result come back so the block is idle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_tiles.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_next(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_request(1'b0);
    endtask

    task automatic test_reset_defaults();
        // The first request after reset starts the walk without a restart.
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        drain();
    endtask

    task automatic test_extreme_sizes();
        write_reg(stog_pkg::CFG_GRID_COLUMNS, 9'd256);
        write_reg(stog_pkg::CFG_GRID_ROWS, 9'd256);
        write_reg(stog_pkg::CFG_TILE_SIZE_LOG2, 9'd8);
        write_reg(CFG_UNUSED_IDX, 9'h1FF);
        send_request(1'b1);
        send_request(1'b0);
        drain();
        // A tile shift above the maximum is clamped.
        write_reg(stog_pkg::CFG_TILE_SIZE_LOG2, 9'h1FF);
        send_request(1'b0);
        drain();
        // Sizes above the maximum side act as the maximum side.
        write_reg(stog_pkg::CFG_GRID_COLUMNS, 9'd511);
        write_reg(stog_pkg::CFG_GRID_ROWS, 9'd300);
        send_request(1'b0);
        drain();
    endtask

    task automatic test_empty_grid();
        write_reg(stog_pkg::CFG_GRID_COLUMNS, 9'd0);
        write_reg(stog_pkg::CFG_TILE_SIZE_LOG2, 9'd0);
        send_request(1'b1);
        drain();
        write_reg(stog_pkg::CFG_GRID_COLUMNS, 9'd5);
        write_reg(stog_pkg::CFG_GRID_ROWS, 9'd0);
        send_request(1'b0);
        drain();
    endtask

    task automatic test_single_tile();
        write_reg(stog_pkg::CFG_GRID_COLUMNS, 9'd1);
        write_reg(stog_pkg::CFG_GRID_ROWS, 9'd1);
        send_request(1'b1);
        send_next(2);
        drain();
    endtask

    task automatic test_spiral_runaway();
        // Widening a one-column grid mid-walk leaves cells the spiral already
        // passed while they were off the grid, so the walk runs out before the
        // tile count is reached.
        write_reg(stog_pkg::CFG_GRID_COLUMNS, 9'd1);
        write_reg(stog_pkg::CFG_GRID_ROWS, 9'd3);
        send_request(1'b1);
        send_next(1);
        drain();
        write_reg(stog_pkg::CFG_GRID_COLUMNS, 9'd3);
        send_next(6);
        drain();
    endtask

    task automatic test_midwalk_change();
        write_reg(stog_pkg::CFG_GRID_COLUMNS, 9'd6);
        write_reg(stog_pkg::CFG_GRID_ROWS, 9'd6);
        send_request(1'b1);
        send_next(2);
        drain();
        write_reg(stog_pkg::CFG_GRID_ROWS, 9'd4);
        write_reg(stog_pkg::CFG_TILE_SIZE_LOG2, 9'd2);
        send_next(3);
        drain();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        write_reg(stog_pkg::CFG_GRID_COLUMNS, 9'd16);
        write_reg(stog_pkg::CFG_GRID_ROWS, 9'd16);
        write_reg(stog_pkg::CFG_TILE_SIZE_LOG2, 9'd4);
        @(posedge i_clk);
        hold_cycles = 300;
        send_request(1'b1);
        send_next(20);
        drain();
    endtask

    task automatic test_random_walks(input int send_pct, input int recv_pct, input int n_items);
        int sent;
        int total;
        int walk_len;
        int i;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            drain();
            write_reg(stog_pkg::CFG_GRID_COLUMNS, random_side());
            write_reg(stog_pkg::CFG_GRID_ROWS, random_side());
            if ($urandom_range(9) < 3)
                write_reg(stog_pkg::CFG_TILE_SIZE_LOG2,
                          stog_pkg::CFG_DATA_W'($urandom_range(511)));
            else
                write_reg(stog_pkg::CFG_TILE_SIZE_LOG2,
                          stog_pkg::CFG_DATA_W'($urandom_range(8)));
            if ($urandom_range(7) == 0)
                write_reg(CFG_UNUSED_IDX, stog_pkg::CFG_DATA_W'($urandom_range(511)));
            total = clamp_side(grid_cols_q) * clamp_side(grid_rows_q);
            walk_len = $urandom_range((total + 3 < 40) ? total + 3 : 40, 1);
            send_request($urandom_range(9) != 0);
            for (i = 0; i < walk_len; i++)
                send_request($urandom_range(19) == 0);
            sent += walk_len + 1;
        end
        drain();
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_tile_result seen;
        t_tile_result want;
        bit bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = '{o_tile_column, o_tile_row, o_pixel_x, o_pixel_y,
                     o_order_number, o_is_last, o_exhausted};
            if (pending_tiles.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result item: col %0d row %0d exhausted %0b",
                             seen.tile_column, seen.tile_row, seen.exhausted);
            end else begin
                want = pending_tiles.pop_front();
                bad = (seen.tile_column !== want.tile_column)
                   || (seen.tile_row !== want.tile_row)
                   || (seen.pixel_x !== want.pixel_x)
                   || (seen.pixel_y !== want.pixel_y)
                   || (seen.order_number !== want.order_number)
                   || (seen.is_last !== want.is_last)
                   || (seen.exhausted !== want.exhausted);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display({"mismatch expected: col %0d row %0d px %0d py %0d",
                                  " order %0d last %0b exh %0b"},
                                 want.tile_column, want.tile_row, want.pixel_x,
                                 want.pixel_y, want.order_number, want.is_last,
                                 want.exhausted);
                        $display({"         actual:   col %0d row %0d px %0d py %0d",
                                  " order %0d last %0b exh %0b"},
                                 seen.tile_column, seen.tile_row, seen.pixel_x,
                                 seen.pixel_y, seen.order_number, seen.is_last,
                                 seen.exhausted);
                    end
                end
                if (want.exhausted)
                    exhausted_seen++;
                else
                    tiles_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_tiles.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        send_idle_pct  = 10;
        recv_stall_pct = 30;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_extreme_sizes();
        test_empty_grid();
        test_single_tile();
        test_spiral_runaway();
        test_midwalk_change();
        test_output_backpressure();
        test_random_walks(16, 72, 200);
        test_random_walks(72, 16, 200);
        test_random_walks(0, 0, 200);

        repeat (4 * SETTLE) @(posedge i_clk);
        $display("Sent %0d tile requests (%0d with restart) over directed and random grids.",
                 requests_sent, restarts_sent);
        $display("Checked %0d tiles and %0d exhausted answers; %0d mismatches.",
                 tiles_checked, exhausted_seen, mismatch_count);
        if (mismatch_count == 0 && pending_tiles.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
